>>> rtl/assert_macros.svh
// Assertion helpers for the RTL files; quaternion_to_affine_rows includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define QTA_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define QTA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/qta_pkg.sv
`default_nettype none
package qta_pkg;

   // Result status codes.
   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_NO_QUAT     = 2'd1;
   localparam logic [1:0] STATUS_BAD_SPACING = 2'd2;

   // One in Q.60 and the 1e-7 radicand threshold in Q.60.
   localparam logic [63:0] ONE_Q60      = 64'h1000_0000_0000_0000;
   localparam logic [63:0] A2_THRESHOLD = 64'd115292150461;

   // Index of the final row of an item.
   localparam logic [1:0] LAST_ROW = 2'd2;

   // Item state carried along the pipeline.
   typedef struct packed {
      logic signed [31:0] b;
      logic signed [31:0] c;
      logic signed [31:0] d;
      logic signed [31:0] sp0;
      logic signed [31:0] sp1;
      logic signed [31:0] sp2;
      logic signed [31:0] off0;
      logic signed [31:0] off1;
      logic signed [31:0] off2;
      logic [31:0]        root;
      logic [1:0]         status;
      logic               path_a;
   } item_type;

   // Divide by 2^30, rounding half away from zero.
   function automatic logic signed [63:0] shr_round30(input logic signed [63:0] v);
      logic [63:0] mag;
      logic [63:0] res;
      mag = v[63] ? (64'd0 - v) : v;
      res = (mag + (64'd1 << 29)) >> 30;
      return v[63] ? $signed(64'd0 - res) : $signed(res);
   endfunction

   // Clamp a rounded rotation entry to plus or minus 2^31.
   function automatic logic signed [32:0] clamp_rot(input logic signed [63:0] v);
      logic signed [32:0] res;
      if (v > 64'sd2147483648) begin
         res = 33'sd2147483648;
      end else if (v < -64'sd2147483648) begin
         res = -33'sd2147483648;
      end else begin
         res = v[32:0];
      end
      return res;
   endfunction

   // Saturate to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] res;
      if (v > 64'sd2147483647) begin
         res = 32'sh7fff_ffff;
      end else if (v < -64'sd2147483648) begin
         res = 32'sh8000_0000;
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

endpackage
`default_nettype wire

>>> rtl/qta_sqrt_pipe.sv
`default_nettype none
module qta_sqrt_pipe (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [63:0]       in_rad,
   input  qta_pkg::item_type      in_item,
   output logic                   out_valid,
   output logic [31:0]            out_root,
   output qta_pkg::item_type      out_item
);
   import qta_pkg::*;

   logic [63:0] rem_ff  [32];
   logic [31:0] root_ff [32];
   item_type    item_ff [32];
   logic        vld_ff  [32];

   // One result bit per stage, most significant first.
   for (genvar k = 0; k < 32; k++) begin : g_step
      localparam int Bit = 31 - k;
      logic [63:0] rem_src;
      logic [31:0] root_src;
      item_type    item_src;
      logic        vld_src;
      logic [64:0] trial;
      logic        take;
      logic [63:0] rem_in;
      logic [31:0] root_in;

      if (k == 0) begin : g_first
         assign rem_src  = in_rad;
         assign root_src = 32'd0;
         assign item_src = in_item;
         assign vld_src  = in_valid;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign item_src = item_ff[k-1];
         assign vld_src  = vld_ff[k-1];
      end

      // Growth of the square when this bit is set: 2*root*2^Bit + 2^(2*Bit).
      assign trial   = ({33'd0, root_src} << (Bit + 1)) | (65'd1 << (2 * Bit));
      assign take    = {1'b0, rem_src} >= trial;
      assign rem_in  = take ? (rem_src - trial[63:0]) : rem_src;
      assign root_in = take ? (root_src | (32'd1 << Bit)) : root_src;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            item_ff[k] <= item_src;
         end
      end
   end

   assign out_valid = vld_ff[31];
   assign out_root  = root_ff[31];
   assign out_item  = item_ff[31];

endmodule
`default_nettype wire

>>> rtl/qta_div_pipe.sv
`default_nettype none
module qta_div_pipe (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [2:0][61:0]  in_num,
   input  qta_pkg::item_type      in_item,
   output logic                   out_valid,
   output logic [2:0][30:0]       out_quo,
   output qta_pkg::item_type      out_item
);
   import qta_pkg::*;

   logic [2:0][61:0] rem_ff  [31];
   logic [2:0][30:0] quo_ff  [31];
   item_type         item_ff [31];
   logic             vld_ff  [31];

   // Restoring division of three lanes by the common root, one quotient bit a stage.
   for (genvar k = 0; k < 31; k++) begin : g_step
      localparam int Bit = 30 - k;
      logic [2:0][61:0] rem_src;
      logic [2:0][30:0] quo_src;
      item_type         item_src;
      logic             vld_src;
      logic [62:0]      cmp;
      logic [2:0][61:0] rem_in;
      logic [2:0][30:0] quo_in;

      if (k == 0) begin : g_first
         assign rem_src  = in_num;
         assign quo_src  = '0;
         assign item_src = in_item;
         assign vld_src  = in_valid;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign quo_src  = quo_ff[k-1];
         assign item_src = item_ff[k-1];
         assign vld_src  = vld_ff[k-1];
      end

      assign cmp = {31'd0, item_src.root} << Bit;

      always_comb begin
         for (int l = 0; l < 3; l++) begin
            if ({1'b0, rem_src[l]} >= cmp) begin
               rem_in[l] = rem_src[l] - cmp[61:0];
               quo_in[l] = quo_src[l] | (31'd1 << Bit);
            end else begin
               rem_in[l] = rem_src[l];
               quo_in[l] = quo_src[l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            quo_ff[k]  <= quo_in;
            item_ff[k] <= item_src;
         end
      end
   end

   assign out_valid = vld_ff[30];
   assign out_quo   = quo_ff[30];
   assign out_item  = item_ff[30];

endmodule
`default_nettype wire

>>> rtl/quaternion_to_affine_rows.sv
// An item passes stages 1 and 2, the square root, the divider, stages 4 to 9 and the output stage.
// Each item leaves as three rows, one per cycle while rsp_ready is high, and the whole pipeline
// holds while rows remain and stage 9 is full; an error item leaves a single result.
// The square root (32 stages) and the normalizing divider (31 stages) fill the depth.
// Reset is synchronous and clears all valid bits and the output stage's busy flag and row counter.
`default_nettype none
`include "assert_macros.svh"
module quaternion_to_affine_rows (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [31:0] req_quat_b,
   input  wire logic signed [31:0] req_quat_c,
   input  wire logic signed [31:0] req_quat_d,
   input  wire logic signed [31:0] req_spacing_x,
   input  wire logic signed [31:0] req_spacing_y,
   input  wire logic signed [31:0] req_spacing_z,
   input  wire logic               req_left_handed,
   input  wire logic signed [31:0] req_offset_x,
   input  wire logic signed [31:0] req_offset_y,
   input  wire logic signed [31:0] req_offset_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_row_index,
   output logic signed [31:0]      rsp_col0,
   output logic signed [31:0]      rsp_col1,
   output logic signed [31:0]      rsp_col2,
   output logic signed [31:0]      rsp_col3,
   output logic [1:0]              rsp_status,
   output logic                    rsp_last_row
);
   import qta_pkg::*;

   logic adv;
   logic take_item;

   // Stage 1: squares of the quaternion parts and the spacing check.
   logic signed [63:0] sq_b_full, sq_c_full, sq_d_full;
   logic [62:0]        sq_b_ff, sq_c_ff, sq_d_ff;
   logic               bad_ff, bad_in;
   item_type           item1_ff, item1_in;
   logic               vld1_ff;

   assign sq_b_full = req_quat_b * req_quat_b;
   assign sq_c_full = req_quat_c * req_quat_c;
   assign sq_d_full = req_quat_d * req_quat_d;
   assign bad_in = (req_spacing_x <= 32'sd0) || (req_spacing_y <= 32'sd0)
                || (req_spacing_z <= 32'sd0);

   always_comb begin
      item1_in        = '0;
      item1_in.b      = req_quat_b;
      item1_in.c      = req_quat_c;
      item1_in.d      = req_quat_d;
      item1_in.sp0    = req_spacing_x;
      item1_in.sp1    = req_spacing_y;
      item1_in.sp2    = req_left_handed ? -req_spacing_z : req_spacing_z;
      item1_in.off0   = req_offset_x;
      item1_in.off1   = req_offset_y;
      item1_in.off2   = req_offset_z;
      item1_in.status = STATUS_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_b_ff  <= sq_b_full[62:0];
         sq_c_ff  <= sq_c_full[62:0];
         sq_d_ff  <= sq_d_full[62:0];
         bad_ff   <= bad_in;
         item1_ff <= item1_in;
      end
   end

   // Stage 2: sum of squares, path choice, status and square root radicand.
   logic [63:0] sum;
   logic        path_a;
   logic [63:0] rad2_ff, rad2_in;
   item_type    item2_ff, item2_in;
   logic        vld2_ff;

   assign sum    = {1'b0, sq_b_ff} + {1'b0, sq_c_ff} + {1'b0, sq_d_ff};
   assign path_a = (sum < ONE_Q60) && ((ONE_Q60 - sum) > A2_THRESHOLD);

   // The absent test belongs to the normalizing path only; all-zero parts take the real-part path.
   always_comb begin
      item2_in        = item1_ff;
      item2_in.path_a = path_a;
      rad2_in         = path_a ? (ONE_Q60 - sum) : sum;
      if (!path_a && (sum == 64'd0)) begin
         item2_in.status = STATUS_NO_QUAT;
      end else if (bad_ff) begin
         item2_in.status = STATUS_BAD_SPACING;
      end else begin
         item2_in.status = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
      end else if (adv) begin
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rad2_ff  <= rad2_in;
         item2_ff <= item2_in;
      end
   end

   // Square root: the real part a, or the norm on the normalizing path.
   logic        sq_vld;
   logic [31:0] sq_root;
   item_type    sq_item;

   qta_sqrt_pipe u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (vld2_ff),
      .in_rad    (rad2_ff),
      .in_item   (item2_ff),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_item  (sq_item)
   );

   // Dividends |x| * 2^30 + root / 2 for the three parts (the root is the norm on the normalizing path).
   item_type         div_item;
   logic [2:0][61:0] div_num;
   logic [31:0]      mag_b, mag_c, mag_d;

   assign mag_b = sq_item.b[31] ? (32'd0 - sq_item.b) : sq_item.b;
   assign mag_c = sq_item.c[31] ? (32'd0 - sq_item.c) : sq_item.c;
   assign mag_d = sq_item.d[31] ? (32'd0 - sq_item.d) : sq_item.d;

   always_comb begin
      div_item      = sq_item;
      div_item.root = sq_root;
      div_num[0]    = {mag_b, 30'd0} + {31'd0, sq_root[31:1]};
      div_num[1]    = {mag_c, 30'd0} + {31'd0, sq_root[31:1]};
      div_num[2]    = {mag_d, 30'd0} + {31'd0, sq_root[31:1]};
   end

   logic             dv_vld;
   logic [2:0][30:0] dv_quo;
   item_type         dv_item;

   qta_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (sq_vld),
      .in_num    (div_num),
      .in_item   (div_item),
      .out_valid (dv_vld),
      .out_quo   (dv_quo),
      .out_item  (dv_item)
   );

   // Stage 4: pick the quaternion (a, b, c, d) for the chosen path.
   logic signed [31:0] qa_ff, qb_ff, qc_ff, qd_ff;
   logic signed [31:0] qa_in, qb_in, qc_in, qd_in;
   logic signed [31:0] nb, nc, nd;
   item_type           item4_ff;
   logic               vld4_ff;

   assign nb = dv_item.b[31] ? -$signed({1'b0, dv_quo[0]}) : $signed({1'b0, dv_quo[0]});
   assign nc = dv_item.c[31] ? -$signed({1'b0, dv_quo[1]}) : $signed({1'b0, dv_quo[1]});
   assign nd = dv_item.d[31] ? -$signed({1'b0, dv_quo[2]}) : $signed({1'b0, dv_quo[2]});
   assign qa_in = dv_item.path_a ? $signed(dv_item.root) : 32'sd0;
   assign qb_in = dv_item.path_a ? dv_item.b : nb;
   assign qc_in = dv_item.path_a ? dv_item.c : nc;
   assign qd_in = dv_item.path_a ? dv_item.d : nd;

   // Stage 5: the ten pairwise products.
   logic signed [63:0] p_aa_ff, p_bb_ff, p_cc_ff, p_dd_ff, p_bc_ff;
   logic signed [63:0] p_ad_ff, p_bd_ff, p_ac_ff, p_cd_ff, p_ab_ff;
   item_type           item5_ff;
   logic               vld5_ff;

   // Stage 6: rotation entries in Q.60.
   logic signed [63:0] rot_ff [3][3];
   logic signed [63:0] rot_in [3][3];
   item_type           item6_ff;
   logic               vld6_ff;

   always_comb begin
      rot_in[0][0] = p_aa_ff + p_bb_ff - p_cc_ff - p_dd_ff;
      rot_in[0][1] = (p_bc_ff - p_ad_ff) <<< 1;
      rot_in[0][2] = (p_bd_ff + p_ac_ff) <<< 1;
      rot_in[1][0] = (p_bc_ff + p_ad_ff) <<< 1;
      rot_in[1][1] = p_aa_ff + p_cc_ff - p_bb_ff - p_dd_ff;
      rot_in[1][2] = (p_cd_ff - p_ab_ff) <<< 1;
      rot_in[2][0] = (p_bd_ff - p_ac_ff) <<< 1;
      rot_in[2][1] = (p_cd_ff + p_ab_ff) <<< 1;
      rot_in[2][2] = p_aa_ff + p_dd_ff - p_cc_ff - p_bb_ff;
   end

   // Stage 7: round to Q.30 and clamp.
   logic signed [32:0] q_ff [3][3];
   logic signed [32:0] q_in [3][3];
   item_type           item7_ff;
   logic               vld7_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            q_in[r][k] = clamp_rot(shr_round30(rot_ff[r][k]));
         end
      end
   end

   // Stage 8: scale each column by its spacing.
   logic signed [63:0] ps_ff [3][3];
   logic signed [63:0] ps_in [3][3];
   logic signed [64:0] ps_full [3][3];
   logic signed [31:0] sp7 [3];
   item_type           item8_ff;
   logic               vld8_ff;

   assign sp7[0] = item7_ff.sp0;
   assign sp7[1] = item7_ff.sp1;
   assign sp7[2] = item7_ff.sp2;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            ps_full[r][k] = q_ff[r][k] * sp7[k];
            ps_in[r][k]   = ps_full[r][k][63:0];
         end
      end
   end

   // Stage 9: round to Q16.16 and saturate.
   logic signed [31:0] v_ff [3][3];
   logic signed [31:0] v_in [3][3];
   item_type           item9_ff;
   logic               vld9_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            v_in[r][k] = sat32(shr_round30(ps_ff[r][k]));
         end
      end
   end

   // Valid bits of stages 4 to 9.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
         vld6_ff <= 1'b0;
         vld7_ff <= 1'b0;
         vld8_ff <= 1'b0;
         vld9_ff <= 1'b0;
      end else if (adv) begin
         vld4_ff <= dv_vld;
         vld5_ff <= vld4_ff;
         vld6_ff <= vld5_ff;
         vld7_ff <= vld6_ff;
         vld8_ff <= vld7_ff;
         vld9_ff <= vld8_ff;
      end
   end

   // Data of stages 4 to 9.
   always_ff @(posedge clock) begin
      if (adv) begin
         qa_ff    <= qa_in;
         qb_ff    <= qb_in;
         qc_ff    <= qc_in;
         qd_ff    <= qd_in;
         item4_ff <= dv_item;
         p_aa_ff  <= qa_ff * qa_ff;
         p_bb_ff  <= qb_ff * qb_ff;
         p_cc_ff  <= qc_ff * qc_ff;
         p_dd_ff  <= qd_ff * qd_ff;
         p_bc_ff  <= qb_ff * qc_ff;
         p_ad_ff  <= qa_ff * qd_ff;
         p_bd_ff  <= qb_ff * qd_ff;
         p_ac_ff  <= qa_ff * qc_ff;
         p_cd_ff  <= qc_ff * qd_ff;
         p_ab_ff  <= qa_ff * qb_ff;
         item5_ff <= item4_ff;
         rot_ff   <= rot_in;
         item6_ff <= item5_ff;
         q_ff     <= q_in;
         item7_ff <= item6_ff;
         ps_ff    <= ps_in;
         item8_ff <= item7_ff;
         v_ff     <= v_in;
         item9_ff <= item8_ff;
      end
   end

   // Output stage: holds one item and sends its rows one per transaction.
   logic signed [31:0] ov_ff [3][3];
   item_type           oitem_ff;
   logic               busy_ff;
   logic [1:0]         row_ff;
   logic               err;

   assign err          = oitem_ff.status != STATUS_OK;
   assign rsp_valid    = busy_ff;
   assign rsp_last_row = err || (row_ff == LAST_ROW);
   assign take_item    = !busy_ff || (rsp_ready && rsp_last_row);
   assign adv          = take_item || !vld9_ff;
   assign req_ready    = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         row_ff  <= 2'd0;
      end else if (take_item) begin
         busy_ff <= vld9_ff;
         row_ff  <= 2'd0;
      end else if (rsp_ready) begin
         row_ff  <= row_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (take_item && vld9_ff) begin
         ov_ff    <= v_ff;
         oitem_ff <= item9_ff;
      end
   end

   // Row selection; an error result is row 0 with all entries zero.
   always_comb begin
      rsp_status    = oitem_ff.status;
      rsp_row_index = err ? 2'd0 : row_ff;
      case (row_ff)
         2'd0: begin
            rsp_col0 = ov_ff[0][0];
            rsp_col1 = ov_ff[0][1];
            rsp_col2 = ov_ff[0][2];
            rsp_col3 = oitem_ff.off0;
         end
         2'd1: begin
            rsp_col0 = ov_ff[1][0];
            rsp_col1 = ov_ff[1][1];
            rsp_col2 = ov_ff[1][2];
            rsp_col3 = oitem_ff.off1;
         end
         2'd2: begin
            rsp_col0 = ov_ff[2][0];
            rsp_col1 = ov_ff[2][1];
            rsp_col2 = ov_ff[2][2];
            rsp_col3 = oitem_ff.off2;
         end
         default: begin
            rsp_col0 = ov_ff[0][0];
            rsp_col1 = ov_ff[0][1];
            rsp_col2 = ov_ff[0][2];
            rsp_col3 = oitem_ff.off0;
         end
      endcase
      if (err) begin
         rsp_col0 = 32'sd0;
         rsp_col1 = 32'sd0;
         rsp_col2 = 32'sd0;
         rsp_col3 = 32'sd0;
      end
   end

   // An error item produces exactly one result.
   `QTA_ASSERT_IMPLIES(a_err_is_last, clock, reset,
      rsp_valid && (rsp_status != STATUS_OK), rsp_last_row,
      "error result not marked as last")

   // After a non-final row the next row of the same item follows.
   `QTA_ASSERT_NEXT(a_row_advance, clock, reset,
      rsp_valid && rsp_ready && !rsp_last_row,
      rsp_valid && (rsp_row_index == 2'($past(rsp_row_index) + 2'd1)),
      "row sequence broken")

   // An empty output stage never holds back the pipeline.
   `QTA_ASSERT_IMPLIES(a_empty_ready, clock, reset, !rsp_valid, req_ready,
      "input stalled while output stage empty")

endmodule
`default_nettype wire
